@@ rtl/canf_pkg.sv @@
// Shared types and constants for the CAN serial adapter transmit framer.
// Depends on nothing; every other file of the framer imports it.
`timescale 1ns / 1ps
`default_nettype none

package canf_pkg;

    // Largest number of payload bytes in one data frame.
    localparam int unsigned MAX_PAYLOAD = 8;

    // Input action codes.
    localparam logic ACT_DATA     = 1'b0;
    localparam logic ACT_SETTINGS = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_START_FLAG = 3'd0;
    localparam logic [2:0] CFG_END_FLAG   = 3'd1;
    localparam logic [2:0] CFG_SPEED_CODE = 3'd2;
    localparam logic [2:0] CFG_MODE_CODE  = 3'd3;
    localparam logic [2:0] CFG_EXT_MODE   = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_START_FLAG = 8'hAA;
    localparam logic [7:0] RST_END_FLAG   = 8'h55;

    // Frame bytes.
    localparam logic [7:0] TYPE_STD     = 8'hC0;
    localparam logic [7:0] TYPE_EXT     = 8'hE0;
    localparam logic [7:0] SET_CMD_HI   = 8'h55;
    localparam logic [7:0] SET_CMD_LO   = 8'h12;
    localparam logic [7:0] SET_ONE      = 8'h01;
    // Constant part of the settings checksum: 0x12, the base of the
    // frame-type code and the 0x01 byte.
    localparam logic [7:0] SET_SUM_BASE = 8'h14;

    // Position of the last byte of a settings frame.
    localparam logic [4:0] SET_LAST_POS = 5'd19;

    // Configuration as seen by the framer stages.
    typedef struct packed {
        logic [7:0] start_flag;
        logic [7:0] end_flag;
        logic [7:0] speed_code;
        logic [7:0] mode_code;
        logic       ext_mode;
    } t_cfg;

    // One classified frame, as queued between front and back end.
    typedef struct packed {
        logic        is_settings;
        logic        ext;
        logic [3:0]  len;
        logic [4:0]  last_pos;
        logic [31:0] can_id;
        logic [63:0] payload;
    } t_frame_desc;

endpackage

`default_nettype wire

@@ rtl/canf_queue.sv @@
// Small first-in first-out queue of frame descriptors between front and back end.
// Depends on canf_pkg for the descriptor type.
`timescale 1ns / 1ps
`default_nettype none

module canf_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_push,
    input  canf_pkg::t_frame_desc    i_wdata,
    output logic                     o_full,
    input  wire                      i_pop,
    output canf_pkg::t_frame_desc    o_rdata,
    output logic                     o_empty
);
    import canf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_frame_desc      r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNT_FULL);
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_rdata   = r_mem[r_rd_ptr];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/canf_front.sv @@
// Front end of the framer: accepts input items and classifies them into frame descriptors.
// Depends on canf_pkg for the descriptor type and codes.
`timescale 1ns / 1ps
`default_nettype none

module canf_front (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_push,
    output logic                     o_full,
    input  wire                      i_action,
    input  wire  [31:0]              i_can_id,
    input  wire  [3:0]               i_dlc,
    input  wire  [63:0]              i_payload,
    input  wire                      i_ext_mode,
    output logic                     o_valid,
    output canf_pkg::t_frame_desc    o_desc,
    input  wire                      i_q_full
);
    import canf_pkg::*;

    localparam logic [3:0] LEN_MAX = 4'(MAX_PAYLOAD);

    logic        r_valid;
    t_frame_desc r_desc;
    t_frame_desc n_desc;
    logic        w_accept;
    logic [3:0]  w_len;

    // The holding register frees up whenever the queue can take its item.
    assign o_full   = r_valid && i_q_full;
    assign w_accept = i_push && !o_full;
    assign o_valid  = r_valid;
    assign o_desc   = r_desc;

    // Classify the item: saturate the length and find the last byte position.
    always_comb begin
        w_len              = (i_dlc > LEN_MAX) ? LEN_MAX : i_dlc;
        n_desc.is_settings = (i_action == ACT_SETTINGS);
        n_desc.ext         = i_ext_mode;
        n_desc.len         = w_len;
        n_desc.can_id      = i_can_id;
        n_desc.payload     = i_payload;
        if (i_action == ACT_SETTINGS) begin
            n_desc.last_pos = SET_LAST_POS;
        end else begin
            // Start, type, identifier bytes, payload, end flag.
            n_desc.last_pos = 5'd2 + (i_ext_mode ? 5'd4 : 5'd2) + {1'b0, w_len};
        end
    end

    // Holding register in front of the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (!i_q_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_desc <= n_desc;
        end
    end

endmodule

`default_nettype wire

@@ rtl/canf_back.sv @@
// Back end of the framer: walks each queued frame and emits one byte per cycle while i_pop is high.
// Depends on canf_pkg for the descriptor and configuration types.
`timescale 1ns / 1ps
`default_nettype none

module canf_back (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_q_empty,
    input  canf_pkg::t_frame_desc    i_desc,
    output logic                     o_q_pop,
    input  canf_pkg::t_cfg           i_cfg,
    output logic                     o_empty,
    input  wire                      i_pop,
    output logic [7:0]               o_out_byte,
    output logic                     o_last
);
    import canf_pkg::*;

    // Byte positions inside a settings frame.
    localparam logic [4:0] POS_START = 5'd0;
    localparam logic [4:0] POS_CMD_H = 5'd1;
    localparam logic [4:0] POS_CMD_L = 5'd2;
    localparam logic [4:0] POS_SPEED = 5'd3;
    localparam logic [4:0] POS_FTYPE = 5'd4;
    localparam logic [4:0] POS_MODE  = 5'd13;
    localparam logic [4:0] POS_ONE   = 5'd14;

    logic [4:0] r_pos;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       w_advance;
    logic       w_at_last;
    logic [4:0] w_id_end;
    logic [4:0] w_id_off;
    logic [4:0] w_pl_off;
    logic [7:0] w_sum;
    logic [7:0] w_set_byte;
    logic [7:0] w_data_byte;
    logic [7:0] n_out_byte;

    assign w_advance  = !i_q_empty && (!r_out_valid || i_pop);
    assign w_at_last  = (r_pos == i_desc.last_pos);
    assign o_q_pop    = w_advance && w_at_last;
    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

    // Settings frame byte at the current position.
    always_comb begin
        w_sum = SET_SUM_BASE + i_cfg.speed_code + i_cfg.mode_code + {7'b0, i_desc.ext};
        unique case (r_pos)
            POS_START:    w_set_byte = i_cfg.start_flag;
            POS_CMD_H:    w_set_byte = SET_CMD_HI;
            POS_CMD_L:    w_set_byte = SET_CMD_LO;
            POS_SPEED:    w_set_byte = i_cfg.speed_code;
            POS_FTYPE:    w_set_byte = SET_ONE + {7'b0, i_desc.ext};
            POS_MODE:     w_set_byte = i_cfg.mode_code;
            POS_ONE:      w_set_byte = SET_ONE;
            SET_LAST_POS: w_set_byte = w_sum;
            default:      w_set_byte = 8'h00;
        endcase
    end

    // Data frame byte at the current position.
    always_comb begin
        w_id_end = i_desc.ext ? 5'd6 : 5'd4;
        w_id_off = r_pos - 5'd2;
        w_pl_off = r_pos - w_id_end;
        priority if (r_pos == POS_START) begin
            w_data_byte = i_cfg.start_flag;
        end else if (r_pos == POS_CMD_H) begin
            w_data_byte = (i_desc.ext ? TYPE_EXT : TYPE_STD) | {4'b0, i_desc.len};
        end else if (r_pos < w_id_end) begin
            w_data_byte = i_desc.can_id[8 * w_id_off[1:0] +: 8];
        end else if (w_at_last) begin
            w_data_byte = i_cfg.end_flag;
        end else begin
            w_data_byte = i_desc.payload[8 * w_pl_off[2:0] +: 8];
        end
    end

    assign n_out_byte = i_desc.is_settings ? w_set_byte : w_data_byte;

    // Byte position within the current frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_advance) begin
            r_pos <= w_at_last ? 5'd0 : r_pos + 5'd1;
        end
    end

    // Output register; it loads whenever a frame is queued and the register is free or being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_byte <= n_out_byte;
            r_out_last <= w_at_last;
        end
    end

endmodule

`default_nettype wire

@@ rtl/can_serial_adapter_tx_framer.sv @@
// Top level of the CAN serial adapter transmit framer: configuration registers and stages.
// Depends on canf_pkg, canf_front, canf_queue and canf_back.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted item becomes one serial frame that leaves one byte per cycle on
// o_out_byte while pop is high, o_last marking its final byte. A data frame has
// 5 to 15 bytes (3 + 2 or 4 identifier bytes + up to 8 payload bytes), a settings
// frame 20 bytes; the back end's byte sequencer sets that rate. The front end takes
// an item while the last is in its holding register if the queue has room, so
// up to QUEUE_DEPTH frames can wait behind the one being sent. Configuration is
// read live by the stages and should only be written while no frame is pending.
module can_serial_adapter_tx_framer #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input items.
    input  wire         push,
    output logic        full,
    input  wire         i_action,
    input  wire  [31:0] i_can_id,
    input  wire  [3:0]  i_dlc,
    input  wire  [63:0] i_payload,
    // Result items.
    output logic        empty,
    input  wire         pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    // Configuration writes.
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [7:0]  i_cfg_data
);
    import canf_pkg::*;

    t_cfg        r_cfg;
    logic        f_valid;
    t_frame_desc f_desc;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    t_frame_desc q_desc;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_flag <= RST_START_FLAG;
            r_cfg.end_flag   <= RST_END_FLAG;
            r_cfg.speed_code <= 8'h00;
            r_cfg.mode_code  <= 8'h00;
            r_cfg.ext_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_FLAG: r_cfg.start_flag <= i_cfg_data;
                CFG_END_FLAG:   r_cfg.end_flag   <= i_cfg_data;
                CFG_SPEED_CODE: r_cfg.speed_code <= i_cfg_data;
                CFG_MODE_CODE:  r_cfg.mode_code  <= i_cfg_data;
                CFG_EXT_MODE:   r_cfg.ext_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Front end: accept and classify.
    canf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_action   (i_action),
        .i_can_id   (i_can_id),
        .i_dlc      (i_dlc),
        .i_payload  (i_payload),
        .i_ext_mode (r_cfg.ext_mode),
        .o_valid    (f_valid),
        .o_desc     (f_desc),
        .i_q_full   (q_full)
    );

    // Descriptor queue between the two ends.
    canf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_wdata (f_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_desc),
        .o_empty (q_empty)
    );

    // Back end: byte sequencer and output register.
    canf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_desc     (q_desc),
        .o_q_pop    (q_pop),
        .i_cfg      (r_cfg),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

    // The queue is never full and empty at once.
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_full && q_empty))
        else $error("descriptor queue reports full and empty together");

    // The back end only retires a frame that is present.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("back end retired a frame from an empty queue");

    // Retiring a frame always loads its final byte into the output register.
    a_retire_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (!empty && o_last))
        else $error("frame retired without its last byte on the output");

endmodule

`default_nettype wire

@@ tb/sv/can_serial_adapter_tx_framer_tb.sv @@
// Self-checking testbench for the CAN serial adapter transmit framer.
// It predicts every frame byte from the register settings and the item fields.
// Depends on canf_pkg and the can_serial_adapter_tx_framer RTL.
`timescale 1ns / 1ps

module can_serial_adapter_tx_framer_tb;
    import canf_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned FRAME_MAX    = SET_LAST_POS + 1;

    // One input item as the framer sees it.
    typedef struct packed {
        logic        action;
        logic [31:0] can_id;
        logic [3:0]  dlc;
        logic [63:0] payload;
    } t_can_item;

    // One predicted byte of a serial frame.
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_frame_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_action;
    logic [31:0] i_can_id;
    logic [3:0]  i_dlc;
    logic [63:0] i_payload;
    logic        empty;
    logic        pop;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [7:0]  i_cfg_data;

    // Register values the framer should hold, and the bytes still owed.
    t_cfg        shadow_cfg;
    t_frame_byte pending_bytes[$];

    int unsigned fail_count     = 0;
    int unsigned items_sent     = 0;
    int unsigned settings_sent  = 0;
    int unsigned bytes_checked  = 0;
    int unsigned frames_checked = 0;
    int unsigned input_stalls   = 0;
    int unsigned cycle_count    = 0;
    int unsigned hold_request   = 0;
    bit          idle_enable    = 1'b1;

    can_serial_adapter_tx_framer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_action   (i_action),
        .i_can_id   (i_can_id),
        .i_dlc      (i_dlc),
        .i_payload  (i_payload),
        .empty      (empty),
        .pop        (pop),
        .o_out_byte (o_out_byte),
        .o_last     (o_last),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Appends the bytes of the frame that one item should produce.
    function automatic void predict_frame(input t_can_item it);
        logic [7:0] frame [FRAME_MAX];
        logic [7:0] sum;
        logic [3:0] len;
        int         n;
        int         id_bytes;
        for (int k = 0; k < FRAME_MAX; k++) begin
            frame[k] = 8'h00;
        end
        if (it.action == ACT_SETTINGS) begin
            frame[0]  = shadow_cfg.start_flag;
            frame[1]  = SET_CMD_HI;
            frame[2]  = SET_CMD_LO;
            frame[3]  = shadow_cfg.speed_code;
            frame[4]  = 8'd1 + {7'd0, shadow_cfg.ext_mode};
            frame[13] = shadow_cfg.mode_code;
            frame[14] = SET_ONE;
            // The checksum covers bytes 2 through 18.
            sum = 8'h00;
            for (int k = 2; k < SET_LAST_POS; k++) begin
                sum = sum + frame[k];
            end
            frame[SET_LAST_POS] = sum;
            n = FRAME_MAX;
        end else begin
            // Lengths past the payload limit are clipped.
            len = (it.dlc > MAX_PAYLOAD) ? 4'(MAX_PAYLOAD) : it.dlc;
            id_bytes = shadow_cfg.ext_mode ? 4 : 2;
            frame[0] = shadow_cfg.start_flag;
            frame[1] = (shadow_cfg.ext_mode ? TYPE_EXT : TYPE_STD) | {4'h0, len};
            n = 2;
            for (int k = 0; k < id_bytes; k++) begin
                frame[n] = it.can_id[8 * k +: 8];
                n = n + 1;
            end
            for (int k = 0; k < int'(len); k++) begin
                frame[n] = it.payload[8 * k +: 8];
                n = n + 1;
            end
            frame[n] = shadow_cfg.end_flag;
            n = n + 1;
        end
        for (int k = 0; k < n; k++) begin
            pending_bytes.push_back('{value: frame[k], last: (k == n - 1)});
        end
    endfunction

    function automatic t_can_item make_item(input logic action, input logic [31:0] can_id,
                                            input logic [3:0] dlc,
                                            input logic [63:0] payload);
        t_can_item it;
        it.action  = action;
        it.can_id  = can_id;
        it.dlc     = dlc;
        it.payload = payload;
        return it;
    endfunction

    // Mostly data frames of legal length, some settings and some long lengths.
    function automatic t_can_item random_item();
        t_can_item it;
        it.action  = ($urandom_range(0, 4) == 0) ? ACT_SETTINGS : ACT_DATA;
        it.can_id  = $urandom;
        it.dlc     = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
        it.payload = {$urandom, $urandom};
        return it;
    endfunction

    // Offers one item and waits until the framer takes it; push stays high afterward.
    task automatic send_item(input t_can_item it);
        int unsigned gap;
        gap = 0;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
        end
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_action  <= it.action;
        i_can_id  <= it.can_id;
        i_dlc     <= it.dlc;
        i_payload <= it.payload;
        @(posedge i_clk);
        while (full) begin
            input_stalls = input_stalls + 1;
            @(posedge i_clk);
        end
        predict_frame(it);
        items_sent = items_sent + 1;
        if (it.action == ACT_SETTINGS) begin
            settings_sent = settings_sent + 1;
        end
    endtask

    // Stops offering items and waits until every predicted byte has come out.
    task automatic drain_frames();
        push <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // One register write; only called while the framer is idle.
    task automatic cfg_write(input logic [2:0] idx, input logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_START_FLAG: shadow_cfg.start_flag = data;
            CFG_END_FLAG:   shadow_cfg.end_flag   = data;
            CFG_SPEED_CODE: shadow_cfg.speed_code = data;
            CFG_MODE_CODE:  shadow_cfg.mode_code  = data;
            CFG_EXT_MODE:   shadow_cfg.ext_mode   = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] start_flag, input logic [7:0] end_flag,
                              input logic [7:0] speed_code, input logic [7:0] mode_code,
                              input logic [7:0] ext_data);
        cfg_write(CFG_START_FLAG, start_flag);
        cfg_write(CFG_END_FLAG, end_flag);
        cfg_write(CFG_SPEED_CODE, speed_code);
        cfg_write(CFG_MODE_CODE, mode_code);
        cfg_write(CFG_EXT_MODE, ext_data);
    endtask

    // Frames built with the register values left by reset.
    task automatic test_reset_values();
        send_item(make_item(ACT_DATA, 32'h0000_0000, 4'd0, 64'h0));
        send_item(make_item(ACT_DATA, 32'hFFFF_FFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
        send_item(make_item(ACT_DATA, 32'h1234_5678, 4'd15, 64'h0123_4567_89AB_CDEF));
        send_item(make_item(ACT_DATA, 32'hABCD_0000, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF));
        send_item(make_item(ACT_SETTINGS, 32'h0, 4'd0, 64'h0));
        drain_frames();
    endtask

    // Registers at all ones and all zeros, plus writes that must be ignored.
    task automatic test_register_extremes();
        set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(make_item(ACT_DATA, 32'hFFFF_FFFF, 4'd0, 64'h0));
        send_item(make_item(ACT_DATA, 32'h8000_0001, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
        send_item(make_item(ACT_DATA, 32'h0000_0000, 4'd9, 64'h8000_0000_0000_0001));
        send_item(make_item(ACT_SETTINGS, 32'hFFFF_FFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF));
        drain_frames();

        set_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(make_item(ACT_DATA, 32'hFFFF_FFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
        send_item(make_item(ACT_SETTINGS, 32'h0, 4'd0, 64'h0));
        drain_frames();

        // Indexes past the last register change nothing.
        for (int k = int'(CFG_EXT_MODE) + 1; k < (1 << $bits(i_cfg_idx)); k++) begin
            cfg_write(3'(k), 8'hFF);
            cfg_write(3'(k), 8'h00);
        end
        // Only bit 0 of the extended-mode write counts.
        cfg_write(CFG_EXT_MODE, 8'hFE);
        send_item(make_item(ACT_DATA, 32'hDEAD_BEEF, 4'd4, 64'h1122_3344_5566_7788));
        send_item(make_item(ACT_SETTINGS, 32'h0, 4'd0, 64'h0));
        drain_frames();
    endtask

    // Random items under several random register settings.
    task automatic test_random_phases();
        for (int phase = 0; phase < 4; phase++) begin
            set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            for (int k = 0; k < 20; k++) begin
                send_item(random_item());
            end
            drain_frames();
        end
    endtask

    // The receiver holds off for a long time while items keep coming.
    task automatic test_input_backpressure();
        idle_enable  = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int k = 0; k < 12; k++) begin
            send_item(random_item());
        end
        drain_frames();
    endtask

    // Back-to-back items with both sides always ready.
    task automatic test_full_rate();
        set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'h01);
        for (int k = 0; k < 16; k++) begin
            send_item(random_item());
        end
        drain_frames();
    endtask

    // Result side: random pop stalls, the long hold-off, and the byte check.
    initial begin : result_checker
        int unsigned stall_left;
        int unsigned hold_left;
        t_frame_byte want;
        stall_left = 0;
        hold_left  = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (pending_bytes.size() == 0) begin
                    $error("unexpected item: out_byte=%02h last=%0b", o_out_byte, o_last);
                    fail_count = fail_count + 1;
                end else begin
                    want = pending_bytes.pop_front();
                    if (o_out_byte !== want.value) begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.value, o_out_byte);
                        fail_count = fail_count + 1;
                    end
                    if (o_last !== want.last) begin
                        $error("last mismatch: expected %0b, actual %0b", want.last, o_last);
                        fail_count = fail_count + 1;
                    end
                    bytes_checked = bytes_checked + 1;
                    if (want.last) begin
                        frames_checked = frames_checked + 1;
                    end
                end
            end
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                pop <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left = stall_left - 1;
                pop <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 16);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Reset, then the tests in order, then the verdict.
    initial begin
        push       <= 1'b0;
        i_action   <= ACT_DATA;
        i_can_id   <= 32'h0;
        i_dlc      <= 4'h0;
        i_payload  <= 64'h0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_START_FLAG;
        i_cfg_data <= 8'h00;
        i_rst_n    <= 1'b0;
        shadow_cfg = '{start_flag: RST_START_FLAG, end_flag: RST_END_FLAG,
                       speed_code: 8'h00, mode_code: 8'h00, ext_mode: 1'b0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_register_extremes();
        test_random_phases();
        test_input_backpressure();
        test_full_rate();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d items (%0d settings frames); checked %0d bytes in %0d frames.",
                 items_sent, settings_sent, bytes_checked, frames_checked);
        $display("Register settings: reset, all ones, all zeros, random; input stalled %0d cycles.",
                 input_stalls);
        if (fail_count == 0 && pending_bytes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
